FILE: src/ksm_pkg.sv
// ksm_pkg: shared constants, register map and types for the key sequence suffix matcher
// no dependencies; imported by ksm_csr, ksm_matcher and key_sequence_suffix_matcher
`timescale 1ns / 1ps

package ksm_pkg;

   // sizing
   localparam int HISTORY_DEPTH   = 14;
   localparam int PATTERN_SLOTS   = 4;
   localparam int PATTERN_MAX_LEN = 8;

   // fixed field widths
   localparam int KEY_W      = 8;
   localparam int PAT_W      = 64;
   localparam int LENS_W     = 16;
   localparam int LEN_W      = 4;
   localparam int SLOT_CAP   = 4;
   localparam int SLOT_W     = 2;
   localparam int HCOUNT_W   = 4;
   localparam logic [LEN_W-1:0] LEN_FIELD_MASK = 4'd15;

   // held key count saturates at the history depth
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(HISTORY_DEPTH);

   // configuration port
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATTERN_KEYS_0  = 3'd0,
      REG_PATTERN_KEYS_1  = 3'd1,
      REG_PATTERN_KEYS_2  = 3'd2,
      REG_PATTERN_KEYS_3  = 3'd3,
      REG_PATTERN_LENGTHS = 3'd4
   } reg_index_type;

   // configuration seen by the matcher
   typedef struct packed {
      logic [SLOT_CAP-1:0][PAT_W-1:0] pattern_keys;
      logic [LENS_W-1:0]              pattern_lengths;
   } pattern_cfg_type;

   // one result word
   typedef struct packed {
      logic                match_found;
      logic [SLOT_W-1:0]   match_slot;
      logic [HCOUNT_W-1:0] history_count;
   } result_type;

endpackage

FILE: src/ksm_csr.sv
// ksm_csr: apb-style register file holding the four patterns and their lengths
// depends on ksm_pkg
`timescale 1ns / 1ps

module ksm_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ksm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ksm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ksm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output ksm_pkg::pattern_cfg_type       cfg
);
   import ksm_pkg::*;

   logic [SLOT_CAP-1:0][PAT_W-1:0] keys_ff, keys_in;
   logic [LENS_W-1:0]              lens_ff, lens_in;
   logic [CSR_IDX_W-1:0]           reg_idx;
   logic                           wr_en;

   // registers are 8 bytes apart
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:3];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      keys_in = keys_ff;
      lens_in = lens_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PATTERN_KEYS_0:  keys_in[0] = csr_pwdata;
            REG_PATTERN_KEYS_1:  keys_in[1] = csr_pwdata;
            REG_PATTERN_KEYS_2:  keys_in[2] = csr_pwdata;
            REG_PATTERN_KEYS_3:  keys_in[3] = csr_pwdata;
            REG_PATTERN_LENGTHS: lens_in    = csr_pwdata[LENS_W-1:0];
            default:             ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PATTERN_KEYS_0:  csr_prdata = keys_ff[0];
         REG_PATTERN_KEYS_1:  csr_prdata = keys_ff[1];
         REG_PATTERN_KEYS_2:  csr_prdata = keys_ff[2];
         REG_PATTERN_KEYS_3:  csr_prdata = keys_ff[3];
         REG_PATTERN_LENGTHS: csr_prdata = {{(CSR_DATA_W-LENS_W){1'b0}}, lens_ff};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
         lens_ff <= '0;
      end else begin
         keys_ff <= keys_in;
         lens_ff <= lens_in;
      end
   end

   assign cfg.pattern_keys    = keys_ff;
   assign cfg.pattern_lengths = lens_ff;

endmodule

FILE: src/ksm_matcher.sv
// ksm_matcher: recent-key history, saturating count and parallel suffix compare
// depends on ksm_pkg; result is combinational from the incoming key
`timescale 1ns / 1ps

module ksm_matcher (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      key_take,
   input  logic [ksm_pkg::KEY_W-1:0] key_code,
   input  ksm_pkg::pattern_cfg_type  cfg,
   output ksm_pkg::result_type       result
);
   import ksm_pkg::*;

   logic [PATTERN_MAX_LEN-1:0][KEY_W-1:0] hist_ff, hist_in;
   logic [CNT_W-1:0]                      count_ff, count_in;
   logic [PATTERN_SLOTS-1:0]              slot_hit;
   logic [CNT_W+HCOUNT_W-1:0]             count_wide;

   // entry 0 is the newest key
   always_comb begin
      hist_in[0] = key_code;
      for (int i = 1; i < PATTERN_MAX_LEN; i++) begin
         hist_in[i] = hist_ff[i-1];
      end
      count_in = (count_ff < CNT_MAX) ? count_ff + CNT_W'(1) : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= '0;
         count_ff <= '0;
      end else if (key_take) begin
         hist_ff  <= hist_in;
         count_ff <= count_in;
      end
   end

   // per slot: check every possible length, then pick the configured one
   always_comb begin
      logic [LEN_W-1:0]            len_raw;
      logic [LEN_W-1:0]            len_sat;
      logic [PATTERN_MAX_LEN:0]    len_ok;
      logic                        eq;
      logic [PAT_W-1:0]            pat;
      for (int k = 0; k < PATTERN_SLOTS; k++) begin
         pat     = cfg.pattern_keys[k];
         len_raw = cfg.pattern_lengths[LEN_W*k +: LEN_W] & LEN_FIELD_MASK;
         len_sat = (len_raw > LEN_W'(PATTERN_MAX_LEN)) ? LEN_W'(PATTERN_MAX_LEN) : len_raw;
         len_ok  = '0;
         for (int l = 1; l <= PATTERN_MAX_LEN; l++) begin
            eq = 1'b1;
            for (int i = 0; i < l; i++) begin
               if (pat[KEY_W*(l-1-i) +: KEY_W] != hist_in[i]) begin
                  eq = 1'b0;
               end
            end
            len_ok[l] = eq;
         end
         slot_hit[k] = (len_sat != '0)
                     && (CMP_W'(len_sat) <= CMP_W'(count_in))
                     && len_ok[len_sat[$clog2(PATTERN_MAX_LEN+1)-1:0]];
      end
   end

   // lowest matching slot wins
   always_comb begin
      result.match_found = 1'b0;
      result.match_slot  = '0;
      for (int k = PATTERN_SLOTS - 1; k >= 0; k--) begin
         if (slot_hit[k]) begin
            result.match_found = 1'b1;
            result.match_slot  = SLOT_W'(k);
         end
      end
   end

   assign count_wide           = {{HCOUNT_W{1'b0}}, count_in};
   assign result.history_count = count_wide[HCOUNT_W-1:0];

endmodule

FILE: src/key_sequence_suffix_matcher.sv
// key_sequence_suffix_matcher: top level, stream channels, csr port and result register
// depends on ksm_pkg, ksm_csr and ksm_matcher
`timescale 1ns / 1ps

// usage
//  - req channel: one key code per word in req_tdata[7:0]
//  - rsp channel: one word per key; rsp_tuser is the match flag, rsp_tdata
//    carries the winning slot (lowest matching slot, 0 if none) and the
//    number of keys now held in history (saturates at 14)
//  - csr port: apb-style, 64-bit data; pattern_keys_0..3 at 0x00..0x18,
//    pattern_lengths at 0x20; write only while no key is in flight
//  - result timing: the result for a key is registered and shows on rsp in the
//    cycle after the key is accepted
//  - throughput: one key per cycle while rsp_tready is high; history update and
//    all four slot compares finish in the cycle of acceptance, feeding the result register
//  - stall: the result register holds its word while rsp_tready is low;
//    req_tready stays high as long as the result register is empty or is
//    being drained in the same cycle, so a stalled receiver stops intake
//    after one buffered word
//  - reset: history, count, patterns and lengths clear to zero and the
//    result register empties; no clearing pass is needed
module key_sequence_suffix_matcher (
   input  logic                           clock,
   input  logic                           reset,
   // key input
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] key_code
   // match results
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [1:0] match_slot, [5:2] history_count, [7:6] zero
   output logic                           rsp_tuser,   // [0] match_found
   // configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ksm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ksm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ksm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import ksm_pkg::*;

   pattern_cfg_type cfg;
   result_type      result;
   result_type      rsp_word_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            req_take;

   ksm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // take a key whenever the result register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   ksm_matcher u_matcher (
      .clock    (clock),
      .reset    (reset),
      .key_take (req_take),
      .key_code (req_tdata[KEY_W-1:0]),
      .cfg      (cfg),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_word_ff.match_found;
   assign rsp_tdata  = {2'b00, rsp_word_ff.history_count, rsp_word_ff.match_slot};

endmodule
